>>> hw/rtl/frame_pool_manager_core_defines.svh
// Assertion macros shared by the frame pool manager RTL.
`ifndef FRAME_POOL_MANAGER_CORE_DEFINES_SVH
`define FRAME_POOL_MANAGER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define FPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fpm_pkg.sv
// Package with types, codes and constants of the frame pool manager.
package fpm_pkg;

  localparam int unsigned FramesDefault = 1024;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned FrameW        = 10;
  localparam int unsigned PoolW         = 2;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned CountW        = 11;

  // Command codes
  localparam logic [CmdW-1:0] CmdAlloc = 2'd0;
  localparam logic [CmdW-1:0] CmdFree  = 2'd1;
  localparam logic [CmdW-1:0] CmdMove  = 2'd2;

  // List codes
  localparam logic [PoolW-1:0] PoolFree = 2'd0;

  // Status codes
  localparam logic [StatusW-1:0] StOk          = 2'd0;
  localparam logic [StatusW-1:0] StNoFree      = 2'd1;
  localparam logic [StatusW-1:0] StBadPool     = 2'd2;
  localparam logic [StatusW-1:0] StAlreadyFree = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DEC,
    S_SWAP,
    S_APP
  } fpm_state_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [FrameW-1:0] frame;
    logic [PoolW-1:0]  dest_list;
  } fpm_cmd_t;

  typedef struct packed {
    logic [FrameW-1:0]  result_frame;
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  list_position;
    logic [CountW-1:0]  free_count;
  } fpm_rsp_t;

endpackage

>>> hw/rtl/fpm_ram.sv
// Simple dual-port synchronous RAM with registered read.
module fpm_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  parameter int unsigned AddrW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/frame_pool_manager_core.sv
// Top level of the frame pool manager: command sequencer, list counts and state memories.
//
// Usage: FRAMES frames live in four dense lists (free, default, recycle, keep).
// A command item is accepted on a rising edge with start_i high and busy_o low.
// Commands: allocate (pop the free list top, append to the target list), free
// (swap-remove from the frame's list, append to the free list) and move (swap-
// remove, append to the target list). Errors come back in the status field.
// Each result is on rsp_o for exactly one cycle with done_o high; the receiver
// cannot stall it, so it must take it in that cycle.
// From the accepting edge an item runs through decode only for allocate, errors
// and moves to the own list, through decode and append for a remove that needs no
// swap, and through decode, swap and append when the last list element is swapped
// into the hole. busy_o falls in the strobe cycle. The sequence is set by the frame
// memory and list memory each having one write port and a registered read.
// After reset a clearing pass writes the frame memory and the free list, one
// entry a cycle, with busy_o high; then the block goes idle.
`include "frame_pool_manager_core_defines.svh"

module frame_pool_manager_core #(
  parameter int unsigned FRAMES = fpm_pkg::FramesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  fpm_pkg::fpm_cmd_t cmd_i,
  output logic             busy_o,
  output logic             done_o,
  output fpm_pkg::fpm_rsp_t rsp_o
);

  localparam int unsigned IdxW  = $clog2(FRAMES);
  localparam int unsigned CntW  = $clog2(FRAMES + 1);
  localparam int unsigned TagW  = fpm_pkg::PoolW;
  localparam int unsigned FrW   = TagW + IdxW;
  localparam int unsigned LstAW = TagW + IdxW;
  localparam int unsigned LstDepth = 4 * (2 ** IdxW);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FRAMES - 1);
  localparam logic [CntW+1:0] SumFull = (CntW + 2)'(FRAMES);

  fpm_pkg::fpm_state_e state_q, state_d;
  logic [IdxW-1:0]     init_q, init_d;
  logic [CntW-1:0]     cnt_q [4];
  logic [CntW-1:0]     cnt_d [4];
  fpm_pkg::fpm_cmd_t   cmd_q;
  logic [TagW-1:0]     src_tag_q, src_tag_d;
  logic [IdxW-1:0]     src_pos_q, src_pos_d;
  logic [TagW-1:0]     dst_q, dst_d;
  logic                done_q, done_d;
  fpm_pkg::fpm_rsp_t   rsp_q, rsp_d;

  logic             fr_we, fr_re;
  logic [IdxW-1:0]  fr_waddr, fr_raddr;
  logic [FrW-1:0]   fr_wdata, fr_rdata;
  logic             lst_we, lst_re;
  logic [LstAW-1:0] lst_waddr, lst_raddr;
  logic [IdxW-1:0]  lst_wdata, lst_rdata;

  logic [TagW-1:0] fr_tag;
  logic [IdxW-1:0] fr_pos;
  logic [TagW-1:0] cnt_sel;
  logic [CntW-1:0] cnt_rd;
  logic [CntW-1:0] src_last;
  logic [CntW-1:0] free_top;
  logic [IdxW-1:0] app_slot;
  logic [IdxW-1:0] alloc_frame;
  logic            is_alloc, is_free, is_move;
  logic            f_oob, dec_done, need_swap;
  logic [CntW+1:0] cnt_sum;

  // Frame memory: list tag and back index per frame
  fpm_ram #(
    .Depth (FRAMES),
    .Width (FrW),
    .AddrW (IdxW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // List memory: four dense lists, addressed by list code and slot
  fpm_ram #(
    .Depth (LstDepth),
    .Width (IdxW),
    .AddrW (LstAW)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .re_i    (lst_re),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  // Decode the item and the memory read data
  assign fr_tag   = fr_rdata[FrW-1 -: TagW];
  assign fr_pos   = fr_rdata[IdxW-1:0];
  assign is_alloc = (cmd_q.cmd == fpm_pkg::CmdAlloc);
  assign is_free  = (cmd_q.cmd == fpm_pkg::CmdFree);
  assign is_move  = (cmd_q.cmd == fpm_pkg::CmdMove);
  assign f_oob    = (32'(cmd_q.frame) >= 32'(FRAMES));

  always_comb begin
    case (state_q)
      fpm_pkg::S_APP: cnt_sel = dst_q;
      default:        cnt_sel = is_alloc ? cmd_q.dest_list : fr_tag;
    endcase
  end

  assign cnt_rd      = cnt_q[cnt_sel];
  assign src_last    = cnt_rd - CntW'(1);
  assign free_top    = cnt_q[0] - CntW'(1);
  assign app_slot    = (32'(cnt_rd) >= 32'(FRAMES)) ? IdxLast : cnt_rd[IdxW-1:0];
  assign alloc_frame = (32'(lst_rdata) >= 32'(FRAMES)) ? '0 : lst_rdata;
  assign need_swap   = ((32'(fr_pos) + 32'd1) < 32'(cnt_rd));

  // Finish in the decode cycle unless the frame must leave its list
  assign dec_done = is_alloc || !(is_free || is_move) || f_oob
                 || (is_free && (fr_tag == fpm_pkg::PoolFree))
                 || (is_move && (cmd_q.dest_list == fpm_pkg::PoolFree))
                 || (is_move && (fr_tag == cmd_q.dest_list));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpm_pkg::S_INIT: begin
        if (init_q == IdxLast) begin
          state_d = fpm_pkg::S_IDLE;
        end
      end
      fpm_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = fpm_pkg::S_DEC;
        end
      end
      fpm_pkg::S_DEC: begin
        if (dec_done) begin
          state_d = fpm_pkg::S_IDLE;
        end else if (need_swap) begin
          state_d = fpm_pkg::S_SWAP;
        end else begin
          state_d = fpm_pkg::S_APP;
        end
      end
      fpm_pkg::S_SWAP: state_d = fpm_pkg::S_APP;
      fpm_pkg::S_APP:  state_d = fpm_pkg::S_IDLE;
      default:         state_d = fpm_pkg::S_IDLE;
    endcase
  end

  // Memory accesses, count updates and result
  always_comb begin
    init_d    = init_q;
    cnt_d     = cnt_q;
    src_tag_d = src_tag_q;
    src_pos_d = src_pos_q;
    dst_d     = dst_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    fr_we     = 1'b0;
    fr_waddr  = '0;
    fr_wdata  = '0;
    fr_re     = 1'b0;
    fr_raddr  = '0;
    lst_we    = 1'b0;
    lst_waddr = '0;
    lst_wdata = '0;
    lst_re    = 1'b0;
    lst_raddr = '0;
    case (state_q)
      fpm_pkg::S_INIT: begin
        // Fill the free list in reverse order and point each frame at its slot
        init_d    = init_q + IdxW'(1);
        fr_we     = 1'b1;
        fr_waddr  = init_q;
        fr_wdata  = {fpm_pkg::PoolFree, IdxLast - init_q};
        lst_we    = 1'b1;
        lst_waddr = {fpm_pkg::PoolFree, init_q};
        lst_wdata = IdxLast - init_q;
      end
      fpm_pkg::S_IDLE: begin
        // Read the frame entry and the free list top ahead of decode
        fr_re     = start_i;
        fr_raddr  = IdxW'(cmd_i.frame);
        lst_re    = start_i;
        lst_raddr = {fpm_pkg::PoolFree, free_top[IdxW-1:0]};
      end
      fpm_pkg::S_DEC: begin
        rsp_d.result_frame  = cmd_q.frame;
        rsp_d.status        = fpm_pkg::StOk;
        rsp_d.list_position = '0;
        if (is_alloc) begin
          rsp_d.result_frame = '0;
          if (cmd_q.dest_list == fpm_pkg::PoolFree) begin
            rsp_d.status = fpm_pkg::StBadPool;
          end else if (cnt_q[0] == '0) begin
            rsp_d.status = fpm_pkg::StNoFree;
          end else begin
            // Pop the free list top and append it to the target list
            cnt_d[0]               = free_top;
            cnt_d[cmd_q.dest_list] = CntW'(app_slot) + CntW'(1);
            fr_we     = 1'b1;
            fr_waddr  = alloc_frame;
            fr_wdata  = {cmd_q.dest_list, app_slot};
            lst_we    = 1'b1;
            lst_waddr = {cmd_q.dest_list, app_slot};
            lst_wdata = alloc_frame;
            rsp_d.result_frame  = fpm_pkg::FrameW'(alloc_frame);
            rsp_d.list_position = fpm_pkg::FrameW'(app_slot);
          end
        end else if (!(is_free || is_move) || f_oob) begin
          rsp_d.status = fpm_pkg::StBadPool;
        end else if (is_free && (fr_tag == fpm_pkg::PoolFree)) begin
          rsp_d.status        = fpm_pkg::StAlreadyFree;
          rsp_d.list_position = fpm_pkg::FrameW'(fr_pos);
        end else if (is_move && (cmd_q.dest_list == fpm_pkg::PoolFree)) begin
          rsp_d.status = fpm_pkg::StBadPool;
        end else if (is_move && (fr_tag == cmd_q.dest_list)) begin
          rsp_d.list_position = fpm_pkg::FrameW'(fr_pos);
        end else begin
          // Drop the frame from its list; fetch the last element if it must fill the hole
          src_tag_d = fr_tag;
          src_pos_d = fr_pos;
          dst_d     = is_free ? fpm_pkg::PoolFree : cmd_q.dest_list;
          if (cnt_rd != '0) begin
            cnt_d[fr_tag] = src_last;
          end
          lst_re    = need_swap;
          lst_raddr = {fr_tag, src_last[IdxW-1:0]};
        end
        if (dec_done) begin
          done_d           = 1'b1;
          rsp_d.free_count = fpm_pkg::CountW'(cnt_d[0]);
        end
      end
      fpm_pkg::S_SWAP: begin
        // Move the last element into the hole and fix its back index
        if (32'(lst_rdata) < 32'(FRAMES)) begin
          fr_we     = 1'b1;
          fr_waddr  = lst_rdata;
          fr_wdata  = {src_tag_q, src_pos_q};
          lst_we    = 1'b1;
          lst_waddr = {src_tag_q, src_pos_q};
          lst_wdata = lst_rdata;
        end
      end
      fpm_pkg::S_APP: begin
        // Append the frame to the destination list
        cnt_d[dst_q] = CntW'(app_slot) + CntW'(1);
        fr_we     = 1'b1;
        fr_waddr  = IdxW'(cmd_q.frame);
        fr_wdata  = {dst_q, app_slot};
        lst_we    = 1'b1;
        lst_waddr = {dst_q, app_slot};
        lst_wdata = IdxW'(cmd_q.frame);
        done_d              = 1'b1;
        rsp_d.result_frame  = cmd_q.frame;
        rsp_d.status        = fpm_pkg::StOk;
        rsp_d.list_position = fpm_pkg::FrameW'(app_slot);
        rsp_d.free_count    = fpm_pkg::CountW'(cnt_d[0]);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpm_pkg::S_INIT;
      init_q   <= '0;
      cnt_q[0] <= CntW'(FRAMES);
      cnt_q[1] <= '0;
      cnt_q[2] <= '0;
      cnt_q[3] <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == fpm_pkg::S_IDLE)) begin
      cmd_q <= cmd_i;
    end
    src_tag_q <= src_tag_d;
    src_pos_q <= src_pos_d;
    dst_q     <= dst_d;
    rsp_q     <= rsp_d;
  end

  assign busy_o = (state_q != fpm_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign cnt_sum = (CntW + 2)'(cnt_q[0]) + (CntW + 2)'(cnt_q[1])
                 + (CntW + 2)'(cnt_q[2]) + (CntW + 2)'(cnt_q[3]);

  // Every frame sits in exactly one list between items
  `FPM_ASSERT_IMP(a_count_sum, state_q == fpm_pkg::S_IDLE, cnt_sum == SumFull, "list counts lost a frame")
  // An accepted item always goes to decode
  `FPM_ASSERT_NXT(a_accept_dec, start_i && !busy_o, state_q == fpm_pkg::S_DEC, "accepted item not decoded")
  // Result strobes are never back to back
  `FPM_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe repeated")
  // A remove never targets the list the frame leaves
  `FPM_ASSERT_IMP(a_swap_lists, state_q == fpm_pkg::S_SWAP, src_tag_q != dst_q, "swap source equals destination")
  // No free frame is only reported with an empty free list
  `FPM_ASSERT_IMP(a_no_free, done_q && (rsp_q.status == fpm_pkg::StNoFree), cnt_q[0] == '0, "bad no-free status")

endmodule

>>> bench/fpm_tb_pkg.sv
// Scoreboard class that tracks the frame lists and predicts each frame pool response.
package fpm_tb_pkg;
  import fpm_pkg::*;

  localparam int unsigned Frames = FramesDefault;

  // Destination lists besides the free list
  localparam logic [PoolW-1:0] PoolDefault = 2'd1;
  localparam logic [PoolW-1:0] PoolRecycle = 2'd2;
  localparam logic [PoolW-1:0] PoolKeep    = 2'd3;

  // Unused command code, answered with a bad-pool status
  localparam logic [CmdW-1:0] CmdIllegal = 2'd3;

  // Cap on mismatch lines shown; all of them are still counted
  localparam int unsigned MaxShown = 40;

  class frame_pool_tracker;
    bit [PoolW-1:0]  list_tag [Frames];
    bit [FrameW-1:0] back_idx [Frames];
    bit [FrameW-1:0] members  [4][Frames];
    int unsigned     list_len [4];
    fpm_rsp_t        pending_rsp_q [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     status_seen [4];

    // Start from the reset layout: every frame free, frame 0 on top
    function new();
      for (int f = 0; f < Frames; f++) begin
        list_tag[f] = PoolFree;
        back_idx[f] = FrameW'(Frames - 1 - f);
        members[PoolFree][f] = FrameW'(Frames - 1 - f);
      end
      list_len[PoolFree]    = Frames;
      list_len[PoolDefault] = 0;
      list_len[PoolRecycle] = 0;
      list_len[PoolKeep]    = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MaxShown) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    // Take a frame out of its list, moving the list's last entry into the hole
    function void unlink(bit [FrameW-1:0] f);
      bit [PoolW-1:0]  t;
      int unsigned     p;
      int unsigned     n;
      bit [FrameW-1:0] last;
      t = list_tag[f];
      p = back_idx[f];
      n = list_len[t];
      if (n == 0) return;
      if (p < n - 1) begin
        last = members[t][n-1];
        members[t][p] = last;
        back_idx[last] = FrameW'(p);
      end
      list_len[t] = n - 1;
    endfunction

    // Put a frame at the end of a list and return its position
    function bit [FrameW-1:0] append(bit [FrameW-1:0] f, bit [PoolW-1:0] d);
      int unsigned n;
      n = list_len[d];
      members[d][n] = f;
      back_idx[f] = FrameW'(n);
      list_tag[f] = d;
      list_len[d] = n + 1;
      return FrameW'(n);
    endfunction

    // Apply an accepted command and queue the response it must produce
    function void note_command(fpm_cmd_t c);
      fpm_rsp_t        want;
      bit [FrameW-1:0] top;
      want = '0;
      case (c.cmd)
        CmdAlloc: begin
          if (c.dest_list == PoolFree) begin
            want.status = StBadPool;
          end else if (list_len[PoolFree] == 0) begin
            want.status = StNoFree;
          end else begin
            list_len[PoolFree]--;
            top = members[PoolFree][list_len[PoolFree]];
            want.result_frame  = top;
            want.list_position = append(top, c.dest_list);
          end
        end
        CmdFree: begin
          want.result_frame = c.frame;
          if (list_tag[c.frame] == PoolFree) begin
            want.status        = StAlreadyFree;
            want.list_position = back_idx[c.frame];
          end else begin
            unlink(c.frame);
            want.list_position = append(c.frame, PoolFree);
          end
        end
        CmdMove: begin
          want.result_frame = c.frame;
          if (c.dest_list == PoolFree) begin
            want.status = StBadPool;
          end else if (list_tag[c.frame] == c.dest_list) begin
            want.list_position = back_idx[c.frame];
          end else begin
            unlink(c.frame);
            want.list_position = append(c.frame, c.dest_list);
          end
        end
        default: begin
          want.result_frame = c.frame;
          want.status       = StBadPool;
        end
      endcase
      want.free_count = CountW'(list_len[PoolFree]);
      pending_rsp_q.push_back(want);
    endfunction

    // Compare a response field by field with the oldest prediction
    function void check_response(fpm_rsp_t got);
      fpm_rsp_t want;
      if (pending_rsp_q.size() == 0) begin
        report($sformatf("response with nothing outstanding: %p", got));
        return;
      end
      want = pending_rsp_q.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.result_frame !== want.result_frame)
        report($sformatf("result_frame %0d, want %0d", got.result_frame, want.result_frame));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d (frame %0d)", got.status, want.status,
                         want.result_frame));
      if (got.list_position !== want.list_position)
        report($sformatf("list_position %0d, want %0d (frame %0d)", got.list_position,
                         want.list_position, want.result_frame));
      if (got.free_count !== want.free_count)
        report($sformatf("free_count %0d, want %0d", got.free_count, want.free_count));
    endfunction

    // Pick a frame that sits in one of the three non-free lists
    function bit [FrameW-1:0] pick_used_frame();
      int unsigned used;
      int unsigned k;
      used = list_len[PoolDefault] + list_len[PoolRecycle] + list_len[PoolKeep];
      if (used == 0) return FrameW'($urandom());
      k = $urandom_range(used - 1, 0);
      for (int d = 1; d < 4; d++) begin
        if (k < list_len[d]) return members[d][k];
        k -= list_len[d];
      end
      return '0;
    endfunction

    function int unsigned free_left();
      return list_len[PoolFree];
    endfunction

    function int unsigned pending();
      return pending_rsp_q.size();
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
// Top-level bench for the frame pool manager: drives commands and checks every response.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpm_pkg::*;
  import fpm_tb_pkg::*;

  // Clearing pass after reset plus several worst-case items
  localparam int unsigned WatchdogLimit = 8 * Frames;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  fpm_cmd_t cmd_i   = '0;
  logic     busy_o;
  logic     done_o;
  fpm_rsp_t rsp_o;

  frame_pool_tracker pool_model;
  int unsigned       sent_per_cmd [4];
  int unsigned       stall_cycles;
  bit                gaps_on;

  always #5 clk_i = ~clk_i;

  frame_pool_manager_core u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .cmd_i,
    .busy_o,
    .done_o,
    .rsp_o
  );

  // Check each response in the one cycle it is offered
  always @(posedge clk_i) begin
    if (rst_ni && done_o) pool_model.check_response(rsp_o);
  end

  // Count cycles in which neither an item nor a response moves
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WatchdogLimit);
    $display("timeout: no progress for %0d cycles", WatchdogLimit);
    $display("FAIL");
    $finish;
  end

  function automatic fpm_cmd_t mk(logic [CmdW-1:0] op, int unsigned frame, int unsigned pool);
    fpm_cmd_t c;
    c.cmd       = op;
    c.frame     = FrameW'(frame);
    c.dest_list = PoolW'(pool);
    return c;
  endfunction

  // Hold the item until the block takes it, then note it for prediction
  task automatic send_item(fpm_cmd_t c);
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pool_model.note_command(c);
    sent_per_cmd[c.cmd]++;
  endtask

  // Drop start for a short random burst now and then
  task automatic idle_gap();
    if (gaps_on && $urandom_range(3, 0) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted response has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pool_model.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly commands on frames that are in use, with some noise
  function automatic fpm_cmd_t rand_item(int unsigned alloc_pct, int unsigned free_pct);
    fpm_cmd_t    c;
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 3) c.cmd = CmdIllegal;
    else if (r < 3 + alloc_pct) c.cmd = CmdAlloc;
    else if (r < 3 + alloc_pct + free_pct) c.cmd = CmdFree;
    else c.cmd = CmdMove;
    c.frame = ($urandom_range(3, 0) != 0) ? pool_model.pick_used_frame() : FrameW'($urandom());
    c.dest_list = ($urandom_range(11, 0) == 0) ? PoolFree : PoolW'($urandom_range(3, 1));
    return c;
  endfunction

  task automatic run_random(int unsigned count, int unsigned alloc_pct, int unsigned free_pct,
                            bit allow_gaps);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) gaps_on = allow_gaps && ($urandom_range(2, 0) != 0);
      send_item(rand_item(alloc_pct, free_pct));
      idle_gap();
    end
  endtask

  initial begin
    fpm_cmd_t directed_items [$];
    pool_model = new();
    gaps_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of every field, each command and the bad-pool and already-free error paths
    directed_items = '{
      mk(CmdAlloc,   Frames - 1, PoolFree),     // no target list
      mk(CmdAlloc,   0,          PoolDefault),  // frame 0
      mk(CmdAlloc,   Frames - 1, PoolDefault),  // frame 1
      mk(CmdAlloc,   682,        PoolDefault),  // frame 2
      mk(CmdAlloc,   0,          PoolRecycle),  // frame 3
      mk(CmdAlloc,   0,          PoolKeep),     // frame 4
      mk(CmdFree,    Frames - 1, PoolDefault),  // frame already free
      mk(CmdFree,    0,          PoolKeep),     // head of default, swap in last
      mk(CmdFree,    1,          PoolDefault),  // last of default, no swap
      mk(CmdMove,    2,          PoolDefault),  // own list
      mk(CmdMove,    2,          PoolFree),     // bad target
      mk(CmdMove,    3,          PoolKeep),     // only entry of recycle
      mk(CmdMove,    Frames - 1, PoolRecycle),  // free frame at bottom of free list
      mk(CmdIllegal, Frames - 1, PoolKeep),
      mk(CmdIllegal, 0,          PoolFree),
      mk(CmdFree,    4,          PoolFree),     // target ignored on free
      mk(CmdMove,    512,        PoolKeep),     // free frame from mid list
      mk(CmdFree,    512,        PoolKeep),
      mk(CmdAlloc,   341,        PoolKeep),
      mk(CmdMove,    2,          PoolRecycle),
      mk(CmdMove,    Frames - 1, PoolDefault),
      mk(CmdFree,    Frames - 1, PoolRecycle)
    };
    foreach (directed_items[i]) begin
      send_item(directed_items[i]);
      idle_gap();
    end

    // Random mix while most frames are still free
    run_random(200, 30, 30, 1'b1);

    // Pause the sender until the block is fully caught up
    wait_drained();

    // Free-heavy mix to hand frames back to the free list
    run_random(120, 10, 55, 1'b1);

    // Back-to-back tail with no idling
    run_random(60, 25, 35, 1'b0);

    start_i <= 1'b0;
    while (pool_model.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pool_model.pending() != 0)
      pool_model.report($sformatf("%0d responses never arrived", pool_model.pending()));

    $display("Covered %0d commands: alloc %0d, free %0d, move %0d, illegal %0d; %0d responses checked",
             sent_per_cmd[0] + sent_per_cmd[1] + sent_per_cmd[2] + sent_per_cmd[3],
             sent_per_cmd[CmdAlloc], sent_per_cmd[CmdFree], sent_per_cmd[CmdMove],
             sent_per_cmd[CmdIllegal], pool_model.checked);
    $display("Status mix: ok %0d, no free %0d, bad pool %0d, already free %0d; %0d mismatches",
             pool_model.status_seen[StOk], pool_model.status_seen[StNoFree],
             pool_model.status_seen[StBadPool], pool_model.status_seen[StAlreadyFree],
             pool_model.mismatches);
    if (pool_model.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
